>>> sv/ptbch_pkg.sv
// Package for the paged token block chain hasher.
// Holds the result kind codes, the FNV-1a constants and the byte fold function.
// No dependencies.
package ptbch_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_BLOCKS    = 64;
    localparam int DEF_BLOCK_ID_BITS = 12;

    // Fixed field widths of the request and result payloads.
    localparam int ID_FIELD_W = 12;
    localparam int SIZE_W     = 9;
    localparam int TOKEN_W    = 32;
    localparam int HASH_W     = 64;

    // Block size limits and the reset value of the register.
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd1;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 9'd256;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd16;

    // Request commands.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_RESET  = 1'b1;

    // FNV-1a 64-bit offset basis. The prime 0x100000001b3 is applied as
    // shifts and adds in fnv_fold_byte.
    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_REJECT  = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_EMPTY   = 2'd3
    } kind_t;

    // One FNV-1a step: xor the byte, then multiply by 2^40 + 0x1b3.
    // 0x1b3 has bits 8, 7, 5, 4, 1 and 0 set.
    function automatic logic [HASH_W-1:0] fnv_fold_byte(
        input logic [HASH_W-1:0] h,
        input logic [7:0]        b
    );
        logic [HASH_W-1:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

>>> sv/paged_token_block_chain_hasher.sv
// Top level of the paged token block chain hasher.
// Holds the sequencer, the running hash and the block table memory.
// Depends on ptbch_pkg.
//
//  Channel  Direction  Handshake               Payload
//  in       request    in_valid / in_ready     cmd, token_id, pool_has_block,
//                                              offered_block_id
//  out      result     out_valid / out_ready   kind, took_block, sealed, block_id,
//                                              block_hash, last
//  cfg      write      cfg_valid / cfg_ready   cfg_data (block size)
//
// An append folds the four token bytes into the hash, one byte per cycle in the
// single fold unit, then loads the result register and returns to idle.
// A rejected append or a reset with nothing held passes through a short state
// that loads the result register, then returns to idle.
// A reset that releases blocks makes one table read per released block and loads
// each release result from the registered read data.
// A request is accepted only while the sequencer is idle; a result waiting in
// the output register stalls the sequencer, not the acceptance of the next request.
// Reset is asynchronous; the block table needs no clearing pass.
module paged_token_block_chain_hasher
    import ptbch_pkg::*;
#(
    parameter int MAX_BLOCKS    = DEF_MAX_BLOCKS,
    parameter int BLOCK_ID_BITS = DEF_BLOCK_ID_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration write channel.
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [SIZE_W-1:0]        cfg_data,
    // Request channel.
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cmd,
    input  logic signed [TOKEN_W-1:0] token_id,
    input  logic                     pool_has_block,
    input  logic [ID_FIELD_W-1:0]    offered_block_id,
    // Result channel.
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               kind,
    output logic                     took_block,
    output logic                     sealed,
    output logic [ID_FIELD_W-1:0]    block_id,
    output logic [HASH_W-1:0]        block_hash,
    output logic                     last
);

    // Stored id width: the offered id masked to BLOCK_ID_BITS and to the field.
    localparam int ID_W   = (BLOCK_ID_BITS < ID_FIELD_W) ? BLOCK_ID_BITS : ID_FIELD_W;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHORT,
        S_HASH,
        S_APPEND,
        S_REL_ADDR,
        S_REL_DATA
    } state_t;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   cfg_size_reg, cfg_size_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [SIZE_W-1:0]   tokens_reg, tokens_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [CNT_W-1:0]    rel_idx_reg, rel_idx_next;
    logic [1:0]          byte_idx_reg, byte_idx_next;
    logic [TOKEN_W-1:0]  tok_reg, tok_next;
    logic                took_reg, took_next;
    kind_t               short_kind_reg, short_kind_next;

    logic                out_valid_reg, out_valid_next;
    kind_t               kind_reg, kind_next;
    logic                took_out_reg, took_out_next;
    logic                sealed_reg, sealed_next;
    logic [ID_FIELD_W-1:0] id_out_reg, id_out_next;
    logic [HASH_W-1:0]   hash_out_reg, hash_out_next;
    logic                last_reg, last_next;

    // Block table memory and its port signals.
    logic [ID_W-1:0]     table_mem [MAX_BLOCKS];
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ID_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic [ID_W-1:0]     rd_data_reg;

    logic                out_free;
    logic                in_accept;
    logic [SIZE_W-1:0]   size_eff;
    logic [SIZE_W-1:0]   tokens_inc;
    logic [CNT_W-1:0]    held_m1;
    logic [CNT_W-1:0]    rel_idx_inc;
    logic                table_full;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign took_block = took_out_reg;
    assign sealed     = sealed_reg;
    assign block_id   = id_out_reg;
    assign block_hash = hash_out_reg;
    assign last       = last_reg;

    // Clamp the block size register into its legal range.
    always_comb
    begin
        if (cfg_size_reg == '0)
            size_eff = SIZE_MIN;
        else if (cfg_size_reg > SIZE_MAX)
            size_eff = SIZE_MAX;
        else
            size_eff = cfg_size_reg;
    end

    assign tokens_inc  = tokens_reg + SIZE_W'(1);
    assign held_m1     = held_reg - CNT_W'(1);
    assign rel_idx_inc = rel_idx_reg + CNT_W'(1);
    assign table_full  = (held_reg >= CNT_W'(MAX_BLOCKS));

    // The read address follows the open block while an append is in work,
    // and the release index otherwise.
    assign mem_raddr = ((state_reg == S_HASH) || (state_reg == S_APPEND))
                       ? held_m1[IDX_W-1:0] : rel_idx_reg[IDX_W-1:0];

    // Block table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= table_mem[mem_raddr];
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        cfg_size_next   = cfg_size_reg;
        hash_next       = hash_reg;
        tokens_next     = tokens_reg;
        held_next       = held_reg;
        rel_idx_next    = rel_idx_reg;
        byte_idx_next   = byte_idx_reg;
        tok_next        = tok_reg;
        took_next       = took_reg;
        short_kind_next = short_kind_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        took_out_next   = took_out_reg;
        sealed_next     = sealed_reg;
        id_out_next     = id_out_reg;
        hash_out_next   = hash_out_reg;
        last_next       = last_reg;

        mem_we    = 1'b0;
        mem_waddr = held_reg[IDX_W-1:0];
        mem_wdata = offered_block_id[ID_W-1:0];

        if (cfg_valid && cfg_ready)
            cfg_size_next = cfg_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    tok_next = token_id;
                    if (cmd == CMD_RESET)
                    begin
                        // Reset the sequence; the held count drives the release loop.
                        hash_next    = FNV_BASIS;
                        tokens_next  = '0;
                        rel_idx_next = '0;
                        if (held_reg == '0)
                        begin
                            short_kind_next = KIND_EMPTY;
                            state_next      = S_SHORT;
                        end
                        else
                        begin
                            state_next = S_REL_ADDR;
                        end
                    end
                    else if ((tokens_reg == '0) && (!pool_has_block || table_full))
                    begin
                        short_kind_next = KIND_REJECT;
                        state_next      = S_SHORT;
                    end
                    else
                    begin
                        // A new block takes the offered id into the table.
                        took_next = (tokens_reg == '0);
                        if (tokens_reg == '0)
                        begin
                            mem_we    = 1'b1;
                            held_next = held_reg + CNT_W'(1);
                        end
                        byte_idx_next = '0;
                        state_next    = S_HASH;
                    end
                end
            end

            S_SHORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = short_kind_reg;
                    took_out_next  = 1'b0;
                    sealed_next    = 1'b0;
                    id_out_next    = '0;
                    hash_out_next  = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_HASH:
            begin
                // Fold one token byte per cycle, least significant first.
                hash_next     = fnv_fold_byte(hash_reg, tok_reg[byte_idx_reg*8 +: 8]);
                byte_idx_next = byte_idx_reg + 2'd1;
                if (byte_idx_reg == 2'd3)
                    state_next = S_APPEND;
            end

            S_APPEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ACCEPT;
                    took_out_next  = took_reg;
                    last_next      = 1'b1;
                    if (tokens_inc >= size_eff)
                    begin
                        // The block is full: report its id and chained hash.
                        sealed_next   = 1'b1;
                        id_out_next   = ID_FIELD_W'(rd_data_reg);
                        hash_out_next = hash_reg;
                        tokens_next   = '0;
                    end
                    else
                    begin
                        sealed_next   = 1'b0;
                        id_out_next   = '0;
                        hash_out_next = '0;
                        tokens_next   = tokens_inc;
                    end
                    state_next = S_IDLE;
                end
            end

            S_REL_ADDR:
            begin
                state_next = S_REL_DATA;
            end

            S_REL_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_RELEASE;
                    took_out_next  = 1'b0;
                    sealed_next    = 1'b0;
                    id_out_next    = ID_FIELD_W'(rd_data_reg);
                    hash_out_next  = '0;
                    last_next      = (rel_idx_inc == held_reg);
                    if (rel_idx_inc == held_reg)
                    begin
                        held_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rel_idx_next = rel_idx_inc;
                        state_next   = S_REL_ADDR;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_size_reg   <= SIZE_RESET;
            hash_reg       <= FNV_BASIS;
            tokens_reg     <= '0;
            held_reg       <= '0;
            rel_idx_reg    <= '0;
            byte_idx_reg   <= '0;
            tok_reg        <= '0;
            took_reg       <= 1'b0;
            short_kind_reg <= KIND_REJECT;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_REJECT;
            took_out_reg   <= 1'b0;
            sealed_reg     <= 1'b0;
            id_out_reg     <= '0;
            hash_out_reg   <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_size_reg   <= cfg_size_next;
            hash_reg       <= hash_next;
            tokens_reg     <= tokens_next;
            held_reg       <= held_next;
            rel_idx_reg    <= rel_idx_next;
            byte_idx_reg   <= byte_idx_next;
            tok_reg        <= tok_next;
            took_reg       <= took_next;
            short_kind_reg <= short_kind_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            took_out_reg   <= took_out_next;
            sealed_reg     <= sealed_next;
            id_out_reg     <= id_out_next;
            hash_out_reg   <= hash_out_next;
            last_reg       <= last_next;
        end
    end

endmodule

>>> sv/ptbch_checker.sv
// Port-level checker for the paged token block chain hasher, with its bind.
// Watches the result and request channels of the top level over time.
// Depends on ptbch_pkg.
module ptbch_checker
    import ptbch_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [1:0]                kind,
    input logic                      took_block,
    input logic                      sealed,
    input logic [ID_FIELD_W-1:0]     block_id,
    input logic [HASH_W-1:0]         block_hash,
    input logic                      last
);

    // A stalled result keeps its valid, its kind, its block id, its hash and its last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(block_id)
            && $stable(block_hash) && $stable(last))
        else $error("stalled result changed");

    // Every kind other than a release is a single result and ends its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_RELEASE) |-> last)
        else $error("single result without last");

    // Only a sealing append carries a hash.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !((kind == KIND_ACCEPT) && sealed) |-> (block_hash == '0))
        else $error("hash on a result that seals nothing");

    // Block take and seal flags appear on accepted appends only.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_ACCEPT) |-> !took_block && !sealed)
        else $error("take or seal flag outside an accepted append");

    // An accepted request keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted in back-to-back cycles");

endmodule

bind paged_token_block_chain_hasher ptbch_checker u_ptbch_checker (.*);
